[rtl/sswq_pkg.sv]
// ----------------------------------------------------------------------------
// sswq_pkg
// Shared types, sizes and codes for the sorted sleep/wakeup queue.
// ----------------------------------------------------------------------------
package sswq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TICK_BITS   = 32;
	localparam int MAX_RESULTS = 16;

	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int POP_W  = $clog2(MAX_RESULTS + 1);
	localparam int WAKE_W = TICK_BITS + 1;

	localparam logic OP_SLEEP = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [1:0] KIND_ACCEPT  = 2'd0;
	localparam logic [1:0] KIND_REJECT  = 2'd1;
	localparam logic [1:0] KIND_WOKEN   = 2'd2;
	localparam logic [1:0] KIND_NOTHING = 2'd3;

	typedef struct packed {
		logic        operation;
		logic [7:0]  thread_id;
		logic [15:0] duration;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  woken_id;
		logic [31:0] tick_now;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [WAKE_W-1:0] wake;
		logic [7:0]        thread;
	} entry_t;

	// circular index: base + offs, modulo the queue depth
	function automatic logic [IDX_W-1:0] idx_wrap(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] offs);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, offs};
		if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
			s = s - (IDX_W+1)'(QUEUE_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

[rtl/sswq_store.sv]
// ----------------------------------------------------------------------------
// sswq_store
// Entry memory of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sswq_store (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [sswq_pkg::IDX_W-1:0] wr_idx,
	input  sswq_pkg::entry_t         wr_data,
	input  logic [sswq_pkg::IDX_W-1:0] rd_idx,
	output sswq_pkg::entry_t         rd_data
);
	import sswq_pkg::*;

	entry_t mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_idx];
	end

endmodule

[rtl/sorted_sleep_wakeup_queue.sv]
// ----------------------------------------------------------------------------
// sorted_sleep_wakeup_queue
// Tick counter with a wake-time sorted queue of sleeping threads.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one word per event: a sleep
//   request (thread id and duration) or a timer tick.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns result words; the final
//   word of each event has last set.
//   Sleep: wake time = count + duration. The entry goes in by a walk from
//   the tail through the entry memory, one entry per cycle, moving each
//   later sleeper up by one place; an empty queue skips the walk.
//   A full queue answers with a reject word and leaves the queue alone.
//   Tick: the counter steps (saturating), then due sleepers are popped from
//   the head at one per cycle unless a woken word waits, up to 16 per tick.
//   One event is in work at a time; req_ready is high when the block is idle.
//   The result register keeps the block working while rsp_ready is low; the
//   sequencer waits only when a second word is ready before the first left.
//   Reset clears the counter and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_sleep_wakeup_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  sswq_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output sswq_pkg::rsp_t  rsp
);
	import sswq_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_PUT  = 3'd2;
	localparam logic [2:0] ST_POP  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

	logic [2:0]           state_q;
	logic [TICK_BITS-1:0] tick_q;
	logic [OCC_W-1:0]     occ_q;
	logic [IDX_W-1:0]     head_q;
	logic [POP_W-1:0]     pops_q;
	logic                 pend_q;
	logic                 rsp_valid_q;

	logic [WAKE_W-1:0]    wake_q;
	logic [7:0]           id_q;
	logic [IDX_W-1:0]     cur_q;
	logic [IDX_W-1:0]     put_q;
	logic [1:0]           kind_q;
	logic [7:0]           pend_id_q;
	rsp_t                 rsp_q;

	logic                 req_fire;
	logic                 out_free;
	logic                 out_load;
	rsp_t                 out_d;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	entry_t               wr_data;
	logic [IDX_W-1:0]     rd_idx;
	entry_t               rd_data;
	logic                 pop_due;
	logic                 pop_emit;
	logic                 pop_go;
	logic                 ins_shift;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pop_due   = (occ_q != '0) && (pops_q < POP_W'(MAX_RESULTS))
		&& (rd_data.wake <= {1'b0, tick_q});
	assign pop_emit  = pend_q || !pop_due;
	assign pop_go    = !pop_emit || out_free;
	assign ins_shift = rd_data.wake > wake_q;

	sswq_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	always_comb begin
		rd_idx   = head_q;
		wr_en    = 1'b0;
		wr_idx   = idx_wrap(head_q, put_q);
		wr_data  = '{wake: wake_q, thread: id_q};
		out_load = 1'b0;
		out_d    = '{kind: kind_q, woken_id: id_q, tick_now: 32'(tick_q), last: 1'b1};
		case (state_q)
			ST_IDLE: begin
				if (req.operation == OP_SLEEP) begin
					rd_idx = idx_wrap(head_q, IDX_W'(occ_q - 1'b1));
				end
			end
			ST_INS: begin
				rd_idx = idx_wrap(head_q, cur_q - 1'b1);
				if (ins_shift) begin
					wr_en   = 1'b1;
					wr_idx  = idx_wrap(head_q, cur_q + 1'b1);
					wr_data = rd_data;
				end
			end
			ST_PUT: begin
				wr_en = 1'b1;
			end
			ST_POP: begin
				if (pop_go && pop_due) begin
					rd_idx = idx_wrap(head_q, IDX_W'(1));
				end
				if (pop_emit && out_free) begin
					out_load = 1'b1;
					if (pend_q) begin
						out_d.kind     = KIND_WOKEN;
						out_d.woken_id = pend_id_q;
						out_d.last     = !pop_due;
					end else begin
						out_d.kind     = KIND_NOTHING;
						out_d.woken_id = 8'd0;
					end
				end
			end
			ST_EMIT: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			occ_q       <= '0;
			head_q      <= '0;
			pops_q      <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.operation == OP_SLEEP) begin
							if (occ_q == OCC_W'(QUEUE_DEPTH)) begin
								state_q <= ST_EMIT;
							end else if (occ_q == '0) begin
								state_q <= ST_PUT;
							end else begin
								state_q <= ST_INS;
							end
						end else begin
							if (tick_q != TICK_MAX) begin
								tick_q <= tick_q + 1'b1;
							end
							pend_q  <= 1'b0;
							pops_q  <= '0;
							state_q <= ST_POP;
						end
					end
				end
				ST_INS: begin
					if (!ins_shift || cur_q == '0) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					occ_q   <= occ_q + 1'b1;
					state_q <= ST_EMIT;
				end
				ST_POP: begin
					if (pop_go) begin
						if (pop_due) begin
							pend_q <= 1'b1;
							head_q <= idx_wrap(head_q, IDX_W'(1));
							occ_q  <= occ_q - 1'b1;
							pops_q <= pops_q + 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= out_d;
		end
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					id_q   <= req.thread_id;
					wake_q <= WAKE_W'(tick_q) + WAKE_W'(req.duration);
					kind_q <= KIND_REJECT;
					cur_q  <= IDX_W'(occ_q - 1'b1);
					put_q  <= '0;
				end
			end
			ST_INS: begin
				if (!ins_shift) begin
					put_q <= cur_q + 1'b1;
				end else if (cur_q == '0) begin
					put_q <= '0;
				end else begin
					cur_q <= cur_q - 1'b1;
				end
			end
			ST_PUT: begin
				kind_q <= KIND_ACCEPT;
			end
			ST_POP: begin
				if (pop_go && pop_due) begin
					pend_id_q <= rd_data.thread;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
